>>> rtl/core/cla_pkg.sv
// ----------------------------------------------------------------------------
// cla_pkg
// shared types and constants of the liquidity amount pipeline
// ----------------------------------------------------------------------------
package cla_pkg;

  localparam int AMT_W     = 63;
  localparam int PRICE_W   = 64;
  localparam int PROD_W    = 128;
  localparam int DIV_STEPS = AMT_W;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SAT      = 2'd1;
  localparam logic [1:0] ST_ZERO_DIV = 2'd2;
  localparam logic [1:0] ST_BAD_RNG  = 2'd3;

  localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};

  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic             use0;
    logic             sat;
    logic [AMT_W-1:0] amt1;
  } side_t;

endpackage

>>> rtl/core/cla_front.sv
// ----------------------------------------------------------------------------
// cla_front
// range classification and selection of the multiplier operands
// ----------------------------------------------------------------------------
module cla_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [62:0]            liquidity,
  input  logic [63:0]            sqrt_price,
  input  logic [63:0]            sqrt_price_lower,
  input  logic [63:0]            sqrt_price_upper,
  output cla_pkg::side_t         side,
  output logic [63:0]            liq,
  output logic [63:0]            d0,
  output logic [63:0]            p,
  output logic [63:0]            q,
  output logic [63:0]            d1
);
  import cla_pkg::*;

  side_t       side_r, side_nxt;
  logic [63:0] liq_r, d0_r, p_r, q_r, d1_r;
  logic [63:0] d0_nxt, p_nxt, q_nxt, d1_nxt;

  always_comb begin
    side_nxt        = '0;
    side_nxt.valid  = in_valid;
    d0_nxt          = '0;
    p_nxt           = 64'd1;
    q_nxt           = 64'd1;
    d1_nxt          = '0;
    if (sqrt_price_lower >= sqrt_price_upper) begin
      side_nxt.status = ST_BAD_RNG;
    end else if (sqrt_price <= sqrt_price_lower) begin
      if (sqrt_price_lower == 64'd0) begin
        side_nxt.status = ST_ZERO_DIV;
      end else begin
        side_nxt.use0 = 1'b1;
        d0_nxt        = sqrt_price_upper - sqrt_price_lower;
        p_nxt         = sqrt_price_lower;
        q_nxt         = sqrt_price_upper;
      end
    end else if (sqrt_price >= sqrt_price_upper) begin
      d1_nxt = sqrt_price_upper - sqrt_price_lower;
    end else begin
      side_nxt.use0 = 1'b1;
      d0_nxt        = sqrt_price_upper - sqrt_price;
      p_nxt         = sqrt_price;
      q_nxt         = sqrt_price_upper;
      d1_nxt        = sqrt_price - sqrt_price_lower;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      liq_r <= {1'b0, liquidity};
      d0_r  <= d0_nxt;
      p_r   <= p_nxt;
      q_r   <= q_nxt;
      d1_r  <= d1_nxt;
    end
  end

  assign side = side_r;
  assign liq  = liq_r;
  assign d0   = d0_r;
  assign p    = p_r;
  assign q    = q_r;
  assign d1   = d1_r;

endmodule

>>> rtl/core/cla_mul.sv
// ----------------------------------------------------------------------------
// cla_mul
// two-stage 64x64 multiplier: 32x32 partial products, then the sum
// ----------------------------------------------------------------------------
module cla_mul (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic [127:0]  prod
);
  import cla_pkg::*;

  logic [63:0]        p00_r, p01_r, p10_r, p11_r;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [64:0]        mid;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= a[31:0]  * b[31:0];
      p01_r <= a[31:0]  * b[63:32];
      p10_r <= a[63:32] * b[31:0];
      p11_r <= a[63:32] * b[63:32];
    end
  end

  always_comb begin
    mid      = {1'b0, p01_r} + {1'b0, p10_r};
    prod_nxt = {p11_r, p00_r} + {31'd0, mid, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

>>> rtl/core/cla_div_step.sv
// ----------------------------------------------------------------------------
// cla_div_step
// one restoring division stage, one quotient bit per stage
// ----------------------------------------------------------------------------
module cla_div_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  cla_pkg::side_t         side_i,
  input  logic [127:0]           rem_i,
  input  logic [127:0]           den_i,
  input  logic [62:0]            quo_i,
  output cla_pkg::side_t         side_o,
  output logic [127:0]           rem_o,
  output logic [127:0]           den_o,
  output logic [62:0]            quo_o
);
  import cla_pkg::*;

  side_t             side_r;
  logic [PROD_W-1:0] rem_r, den_r, rem_nxt;
  logic [AMT_W-1:0]  quo_r, quo_nxt;
  logic [PROD_W:0]   sh, diff;
  logic              ge;

  always_comb begin
    sh      = {rem_i, 1'b0};
    diff    = sh - {1'b0, den_i};
    ge      = sh >= {1'b0, den_i};
    rem_nxt = ge ? diff[PROD_W-1:0] : sh[PROD_W-1:0];
    quo_nxt = {quo_i[AMT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      quo_r <= quo_nxt;
    end
  end

  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign quo_o  = quo_r;

endmodule

>>> rtl/core/concentrated_liquidity_amounts.sv
// ----------------------------------------------------------------------------
// concentrated_liquidity_amounts
// token amounts for a liquidity position over a square-root price range
// ----------------------------------------------------------------------------
// one input beat carries liquidity and three q0.64 square-root prices; one
// output beat carries amount0, amount1 and status for it, in order.
// the block is a 67-stage pipeline: range classification (1), partial
// product multipliers and their sum (2), saturation check (1) and a
// restoring divider with one quotient bit per stage (63).
// one beat is taken every cycle while the receiver keeps out_tready high.
// the last divider stage is the output register. when it holds a beat
// that is not taken, the whole pipeline holds and in_tready falls; all
// stages hold together, so bubbles are not squeezed out.
// reset clears the valid bits of all stages; payload is not reset.
// ----------------------------------------------------------------------------
module concentrated_liquidity_amounts (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // liquidity[62:0], sqrt_price[126:63], sqrt_price_lower[190:127],
  // sqrt_price_upper[254:191], zero[255]
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // amount0[62:0], amount1[125:63], status[127:126]
  output logic [127:0] out_tdata
);
  import cla_pkg::*;

  logic              en;
  side_t             f_side;
  logic [63:0]       f_liq, f_d0, f_p, f_q, f_d1;
  logic [PROD_W-1:0] num, den, prod1;
  side_t             m_side_r [2];
  side_t             s_side_r, s_side_nxt;
  logic [PROD_W-1:0] s_rem_r, s_den_r;
  logic              sat;

  side_t             c_side [DIV_STEPS+1];
  logic [PROD_W-1:0] c_rem  [DIV_STEPS+1];
  logic [PROD_W-1:0] c_den  [DIV_STEPS+1];
  logic [AMT_W-1:0]  c_quo  [DIV_STEPS+1];

  side_t             last;
  logic [AMT_W-1:0]  amt0;
  logic [1:0]        st;

  assign last      = c_side[DIV_STEPS];
  assign en        = !last.valid || out_tready;
  assign in_tready = en;

  cla_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .in_valid         (in_tvalid),
    .liquidity        (in_tdata[62:0]),
    .sqrt_price       (in_tdata[126:63]),
    .sqrt_price_lower (in_tdata[190:127]),
    .sqrt_price_upper (in_tdata[254:191]),
    .side             (f_side),
    .liq              (f_liq),
    .d0               (f_d0),
    .p                (f_p),
    .q                (f_q),
    .d1               (f_d1)
  );

  cla_mul u_mul_num (.clk(clk), .en(en), .a(f_liq), .b(f_d0), .prod(num));
  cla_mul u_mul_den (.clk(clk), .en(en), .a(f_p),   .b(f_q),  .prod(den));
  cla_mul u_mul_one (.clk(clk), .en(en), .a(f_liq), .b(f_d1), .prod(prod1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_side_r[0] <= '0;
      m_side_r[1] <= '0;
    end else if (en) begin
      m_side_r[0] <= f_side;
      m_side_r[1] <= m_side_r[0];
    end
  end

  // quotient reaches 2^63 exactly when 2*num >= den
  assign sat = {num, 1'b0} >= {1'b0, den};

  always_comb begin
    s_side_nxt      = m_side_r[1];
    s_side_nxt.sat  = sat;
    s_side_nxt.amt1 = prod1[PROD_W-2:PRICE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_side_r <= '0;
    end else if (en) begin
      s_side_r <= s_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem_r <= {num[PROD_W-2:0], 1'b0};
      s_den_r <= den;
    end
  end

  assign c_side[0] = s_side_r;
  assign c_rem[0]  = s_rem_r;
  assign c_den[0]  = s_den_r;
  assign c_quo[0]  = '0;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    cla_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .side_i (c_side[i]),
      .rem_i  (c_rem[i]),
      .den_i  (c_den[i]),
      .quo_i  (c_quo[i]),
      .side_o (c_side[i+1]),
      .rem_o  (c_rem[i+1]),
      .den_o  (c_den[i+1]),
      .quo_o  (c_quo[i+1])
    );
  end

  always_comb begin
    amt0 = '0;
    st   = last.status;
    if (last.use0) begin
      amt0 = last.sat ? AMT_MAX : c_quo[DIV_STEPS];
      if (last.sat) begin
        st = ST_SAT;
      end
    end
  end

  assign out_tvalid = last.valid;
  assign out_tdata  = {st, last.amt1, amt0};

endmodule

>>> bench/tb_concentrated_liquidity_amounts.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_concentrated_liquidity_amounts
// stream bench for the liquidity amount pipeline
// ----------------------------------------------------------------------------
// each accepted input beat is turned into an expected amount0/amount1/status
// by wide exact integer math and queued; each output beat is compared with
// the oldest entry. directed corner cases come first, then random beats
// under three idling mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_concentrated_liquidity_amounts;
  import cla_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;

  logic [127:0] amounts_due[$];
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_cycles = 0;
  int           errors = 0;
  int           beats_in = 0;
  int           beats_out = 0;

  localparam logic [63:0] P_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  concentrated_liquidity_amounts DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  // floor(l*d*2^64 / (p*q)) with saturation
  function automatic logic [AMT_W-1:0] div_amount(input logic [AMT_W-1:0] l,
      input logic [63:0] d, input logic [63:0] p, input logic [63:0] q,
      inout logic sat);
    logic [255:0] num;
    logic [255:0] den;
    logic [255:0] quo;
    num = ({193'b0, l} * {192'b0, d}) << 64;
    den = {192'b0, p} * {192'b0, q};
    quo = num / den;
    if (quo > {193'b0, AMT_MAX}) begin
      sat = 1'b1;
      return AMT_MAX;
    end
    return quo[AMT_W-1:0];
  endfunction

  function automatic logic [AMT_W-1:0] shr_amount(input logic [AMT_W-1:0] l,
      input logic [63:0] d, inout logic sat);
    logic [127:0] prod;
    prod = {65'b0, l} * {64'b0, d};
    if (prod[127:64] > {1'b0, AMT_MAX}) begin
      sat = 1'b1;
      return AMT_MAX;
    end
    return prod[126:64];
  endfunction

  function automatic logic [127:0] predict_amounts(input logic [255:0] beat);
    logic [AMT_W-1:0] l;
    logic [63:0]      x, a, b;
    logic [AMT_W-1:0] amt0, amt1;
    logic [1:0]       st;
    logic             sat;
    l = beat[62:0];
    x = beat[126:63];
    a = beat[190:127];
    b = beat[254:191];
    amt0 = '0;
    amt1 = '0;
    st = ST_OK;
    sat = 1'b0;
    if (a >= b) begin
      st = ST_BAD_RNG;
    end else if (x <= a) begin
      if (a == 0) st = ST_ZERO_DIV;
      else amt0 = div_amount(l, b - a, a, b, sat);
    end else if (x >= b) begin
      amt1 = shr_amount(l, b - a, sat);
    end else begin
      amt0 = div_amount(l, b - x, x, b, sat);
      amt1 = shr_amount(l, x - a, sat);
    end
    if (st == ST_OK && sat) st = ST_SAT;
    return {st, amt1, amt0};
  endfunction

  // input monitor: predict on every accepted beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      amounts_due.push_back(predict_amounts(in_tdata));
      beats_in++;
    end
  end

  // output checker
  always @(posedge clk) begin
    logic [127:0] exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (amounts_due.size() == 0) begin
        $error("unexpected output beat %h", out_tdata);
        errors++;
      end else begin
        exp_beat = amounts_due.pop_front();
        if (exp_beat[62:0] !== out_tdata[62:0]) begin
          $error("amount0 expected %0d actual %0d", exp_beat[62:0], out_tdata[62:0]);
          errors++;
        end
        if (exp_beat[125:63] !== out_tdata[125:63]) begin
          $error("amount1 expected %0d actual %0d", exp_beat[125:63],
                 out_tdata[125:63]);
          errors++;
        end
        if (exp_beat[127:126] !== out_tdata[127:126]) begin
          $error("status expected %0d actual %0d", exp_beat[127:126],
                 out_tdata[127:126]);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls plus counted hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(input logic [62:0] l, input logic [63:0] x,
                           input logic [63:0] a, input logic [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, b, a, x, l};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_price();
    case ($urandom_range(5))
      0: return 64'($urandom_range(16));
      1: return P_MAX - 64'($urandom_range(16));
      2: return rand64() >> $urandom_range(63);
      default: return rand64();
    endcase
  endfunction

  function automatic logic [62:0] pick_liq();
    case ($urandom_range(4))
      0: return 63'($urandom_range(3));
      1: return 63'(P_MAX >> 1);
      2: return 63'(rand64() >> $urandom_range(63));
      default: return 63'(rand64());
    endcase
  endfunction

  task automatic test_directed();
    send_beat(63'd1000, 64'd5, 64'd7, 64'd7);           // equal bounds
    send_beat(63'd1000, 64'd5, P_MAX, 64'd1);           // lower above upper
    send_beat('1, 64'd0, 64'd0, P_MAX);                 // zero divisor
    send_beat('1, 64'd0, 64'd0, 64'd1);
    send_beat(63'd12345, 64'd100, 64'd100, 64'd200);    // price at lower bound
    send_beat(63'd12345, 64'd200, 64'd100, 64'd200);    // price at upper bound
    send_beat('1, 64'h8000_0000_0000_0000, 64'd1, P_MAX); // inside the range
    send_beat('1, P_MAX, 64'd0, P_MAX);                 // above, widest range
    send_beat('1, 64'd0, 64'd1, P_MAX);                 // below, saturates
    send_beat('1, 64'd1, P_MAX - 1, P_MAX);
    send_beat(63'd0, 64'h4000_0000_0000_0000, 64'd1, P_MAX);
    send_beat(63'd1, P_MAX - 1, P_MAX - 2, P_MAX);
    send_beat('1, P_MAX - 1, P_MAX - 2, P_MAX);
    send_beat(63'h1234_5678_9ABC, 64'h6000_0000_0000_0000,
              64'h2000_0000_0000_0000, 64'hA000_0000_0000_0000);
    send_beat(63'h1234_5678_9ABC, 64'd3, 64'd1, 64'd5);
    send_beat('1, P_MAX, P_MAX, P_MAX);
    send_beat(63'd0, 64'd0, 64'd0, 64'd0);
  endtask

  task automatic test_random(input int count);
    logic [62:0] l;
    logic [63:0] x, a, b, t;
    for (int i = 0; i < count; i++) begin
      l = pick_liq();
      a = pick_price();
      b = pick_price();
      if ($urandom_range(9) != 0) begin
        if (a > b) begin
          t = a; a = b; b = t;
        end
        if (a == b) begin
          if (b != P_MAX) b = b + 1;
          else a = a - 1;
        end
        case ($urandom_range(6))
          0: x = a;
          1: x = b;
          2: x = (a == 0) ? 64'd0 : 64'($urandom_range(32'(a)));
          3: x = b + 64'($urandom_range(3));
          default: x = a + 1 + ((rand64()) % (b - a));
        endcase
      end else begin
        x = pick_price();
      end
      send_beat(l, x, a, b);
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 300;
    test_random(150);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 26;
    recv_idle_pct = 54;
    test_directed();
    test_random(420);
    send_idle_pct = 54;
    recv_idle_pct = 26;
    test_random(420);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    test_backpressure();
    while (amounts_due.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("covered %0d input beats, %0d output beats: range errors, zero divisor,",
             beats_in, beats_out);
    $display("bounds, saturation, three idling mixes and a long receiver hold-off");
    if (errors == 0 && amounts_due.size() == 0) begin
      $display("tb_concentrated_liquidity_amounts: PASS");
    end else begin
      $display("tb_concentrated_liquidity_amounts: FAIL");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_concentrated_liquidity_amounts: FAIL");
    $finish;
  end

endmodule
